>>> rtl/dct_8x8_forward_inverse_assert.svh
// Assertion macros for the 8x8 DCT block.
`ifndef DCT_8X8_FORWARD_INVERSE_ASSERT_SVH
`define DCT_8X8_FORWARD_INVERSE_ASSERT_SVH
`ifndef SYNTHESIS
`define DCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dct assertion failed");
`define DCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dct assertion failed");
`else
`define DCT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/dct8_pkg.sv
// Types, constants and cosine ROM for the 8x8 DCT block.
package dct8_pkg;
    localparam int BLOCK_SIZE_D    = 8;
    localparam int FRACTION_BITS_D = 4;
    localparam int IN_W            = 13;
    localparam int OUT_W           = 17;
    localparam int ROW_W           = 24;
    localparam int ROW_SHIFT       = 6;
    localparam int TOTAL_FRAC      = 22;
    localparam int ROM_W           = 15;

    typedef struct packed {
        logic signed [IN_W-1:0] in_value;
        logic                   in_last;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_value;
        logic                    out_last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_ROW  = 4'b0010,
        ST_COL  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    function automatic logic signed [ROM_W-1:0] half_cos(input logic [4:0] m);
        logic signed [ROM_W-1:0] v;
        unique case (m[2:0])
            3'd0: v = 15'sd8192;
            3'd1: v = 15'sd8035;
            3'd2: v = 15'sd7568;
            3'd3: v = 15'sd6811;
            3'd4: v = 15'sd5793;
            3'd5: v = 15'sd4551;
            3'd6: v = 15'sd3135;
            default: v = 15'sd1598;
        endcase
        if (m[2:0] == 3'd0 && m[3]) v = 15'sd0;
        // quadrant sign: 8..23 negative (excluding zero points)
        if (m[3]) begin
            unique case (m[2:0])
                3'd0: v = 15'sd0;
                3'd1: v = 15'sd1598;
                3'd2: v = 15'sd3135;
                3'd3: v = 15'sd4551;
                3'd4: v = 15'sd5793;
                3'd5: v = 15'sd6811;
                3'd6: v = 15'sd7568;
                default: v = 15'sd8035;
            endcase
        end
        if ((m[4] ^ m[3]) && !(m[3] && m[2:0] == 3'd0)) v = -v;
        if (m == 5'd16) v = -15'sd8192;
        return v;
    endfunction

    function automatic logic signed [ROM_W-1:0] rom(input logic [2:0] k, input logic [2:0] n);
        logic [7:0] p;
        p = ({4'd0, n, 1'b1}) * {5'd0, k};
        if (k == 3'd0) return 15'sd5793;
        return half_cos(p[4:0]);
    endfunction
endpackage

>>> rtl/dct8_ram.sv
// Generic single-port-write, registered-read RAM.
module dct8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/dct_8x8_forward_inverse.sv
// Top level of the 8x8 forward/inverse DCT block.
// Usage:
//  Input channel: drive i_item and raise start while busy is low; the item is
//  taken at that edge. Sixty-four items form a block in row-major order, the
//  last one with in_last set. Busy stays low between unmarked items.
//  On the marked item busy rises. The block runs a row pass then a column
//  pass, each 64 sums of 8 products. Each product goes through a shift-add
//  multiplier that takes one coefficient bit per cycle, after a phase that
//  issues the memory read and one that loads the operand; each sum ends with
//  a step that writes or shows it and advances the output position.
//  Results: each column sum, once done, is shown on o_item for one cycle with
//  o_valid high; the receiver cannot stall, so it must take it then. out_last
//  marks the 64th result; busy falls in that same cycle.
//  Config: i_cfg_we with i_cfg_data writes direction; write only when idle.
//  Direction is sampled when the marked item arrives.
//  Reset: synchronous active-low i_rst_n returns to loading with index zero
//  and direction forward. The stores hold no reset value.
`include "dct_8x8_forward_inverse_assert.svh"
module dct_8x8_forward_inverse #(
    parameter int FRACTION_BITS = dct8_pkg::FRACTION_BITS_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dct8_pkg::t_in_item i_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    output logic               o_valid,
    output dct8_pkg::t_out_item o_item
);
    import dct8_pkg::*;

    localparam int ACC_W = 48;
    localparam int FSH   = TOTAL_FRAC - FRACTION_BITS;

    t_state r_state, n_state;
    logic [5:0] r_load, n_load;
    logic r_dir, r_inv, n_inv;
    logic [5:0] r_idx, n_idx;      // output position r*8+c
    logic [2:0] r_k, n_k;
    logic [1:0] r_ph, n_ph;        // 0 issue read, 1 wait, 2 multiply
    logic [3:0] r_bit, n_bit;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] r_mc, n_mc;   // multiplicand, shifted left each bit
    logic [ROM_W-1:0] r_mp, n_mp;          // multiplier bits, shifted right
    logic r_ov, n_ov;
    t_out_item r_out, n_out;

    logic accept;
    assign accept = start && !busy;
    assign busy = !r_state[0];

    logic [5:0] in_raddr, row_raddr;
    logic [IN_W-1:0] in_rdata;
    logic [ROW_W-1:0] row_rdata;
    logic row_we;
    logic [ROW_W-1:0] row_wdata;

    dct8_ram #(.WIDTH(IN_W), .DEPTH(64)) u_in (
        .i_clk(i_clk), .i_we(accept), .i_waddr(r_load), .i_wdata(i_item.in_value),
        .i_raddr(in_raddr), .o_rdata(in_rdata));
    dct8_ram #(.WIDTH(ROW_W), .DEPTH(64)) u_row (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(r_idx), .i_wdata(row_wdata),
        .i_raddr(row_raddr), .o_rdata(row_rdata));

    assign in_raddr  = {r_idx[5:3], r_k};
    assign row_raddr = {r_k, r_idx[2:0]};

    logic signed [ROM_W-1:0] w;
    logic [2:0] pos;
    assign pos = r_state[1] ? r_idx[2:0] : r_idx[5:3];
    assign w = r_inv ? rom(r_k, pos) : rom(pos, r_k);

    logic signed [ACC_W-1:0] rsum, rrow, csum, cval;
    logic signed [ACC_W-1:0] sat_in;
    assign rsum = r_acc + (ACC_W'(1) <<< (ROW_SHIFT - 1));
    assign rrow = rsum >>> ROW_SHIFT;
    assign row_wdata = rrow[ROW_W-1:0];
    assign csum = r_acc + (ACC_W'(1) <<< (FSH - 1));
    assign cval = r_acc[ACC_W-1] ?
        -((-r_acc) >>> TOTAL_FRAC) : (r_acc >>> TOTAL_FRAC);
    assign sat_in = r_inv ? cval : (csum >>> FSH);

    logic last_prod;
    assign last_prod = (r_ph == 2'd2) && (r_bit == 4'(ROM_W - 1)) && (r_k == 3'd7);
    assign row_we = r_state[1] && r_ov;

    always_comb begin
        n_state = r_state; n_load = r_load; n_inv = r_inv; n_idx = r_idx; n_k = r_k;
        n_ph = r_ph; n_bit = r_bit; n_acc = r_acc; n_mc = r_mc; n_mp = r_mp;
        n_ov = 1'b0; n_out = r_out;
        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    n_load = r_load + 6'd1;
                    if (i_item.in_last) begin
                        n_load = '0; n_inv = r_dir; n_state = ST_ROW;
                        n_idx = '0; n_k = '0; n_ph = '0; n_acc = '0;
                    end
                end
            end
            ST_ROW, ST_COL: begin
                unique case (r_ph)
                    2'd0: n_ph = 2'd1;
                    2'd1: begin
                        n_ph = 2'd2; n_bit = '0; n_mp = w;
                        n_mc = r_state[1] ? ACC_W'(signed'(in_rdata))
                                          : ACC_W'(signed'(row_rdata));
                    end
                    default: begin
                        // signed shift-add; top bit of w weighs negative
                        if (r_mp[0])
                            n_acc = (r_bit == 4'(ROM_W - 1)) ? r_acc - r_mc : r_acc + r_mc;
                        n_mc = r_mc <<< 1;
                        n_mp = r_mp >> 1;
                        n_bit = r_bit + 4'd1;
                        if (r_bit == 4'(ROM_W - 1)) begin
                            n_ph = 2'd0;
                            n_k = r_k + 3'd1;
                            if (r_k == 3'd7) n_ov = 1'b1;
                        end
                    end
                endcase
                if (r_ov) begin
                    // reissue the first read once the position has advanced
                    n_ph = 2'd0;
                    n_acc = '0;
                    n_idx = r_idx + 6'd1;
                    if (r_state[2]) begin
                        n_out.out_value = (sat_in < -ACC_W'(65536)) ? 17'sh10000 :
                            (sat_in > ACC_W'(65535)) ? 17'sd65535 : sat_in[OUT_W-1:0];
                        n_out.out_last = (r_idx == 6'd63);
                    end
                    if (r_idx == 6'd63) begin
                        n_state = r_state[1] ? ST_COL : ST_LOAD;
                        n_ph = '0;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    logic r_oval;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD; r_load <= '0; r_dir <= 1'b0; r_ov <= 1'b0;
            r_oval <= 1'b0; r_ph <= '0; r_k <= '0; r_idx <= '0;
        end else begin
            r_state <= n_state; r_load <= n_load; r_ov <= n_ov && !(r_ov);
            r_oval <= r_ov && r_state[2];
            r_ph <= n_ph; r_k <= n_k; r_idx <= n_idx;
            if (i_cfg_we) r_dir <= i_cfg_data;
        end
        r_inv <= n_inv; r_bit <= n_bit; r_acc <= n_acc; r_mc <= n_mc; r_mp <= n_mp;
        r_out <= n_out;
    end
    assign o_valid = r_oval;
    assign o_item = r_out;

    `DCT_ASSERT_IMPL(a_out_busy, i_clk, i_rst_n, r_ov, busy)
    `DCT_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, r_ov && r_state[2] && r_idx == 6'd63, !busy)
    `DCT_ASSERT_IMPL(a_noload_busy, i_clk, i_rst_n, busy, r_load == 6'd0)
endmodule
